### hw/rtl/lipa_pkg.sv
// ----------------------------------------------------------------------------
// lipa_pkg
// Shared types, codes and widths of the LIFO index pool allocator.
// ----------------------------------------------------------------------------
package lipa_pkg;

	localparam int unsigned POOL_ENTRIES_DEF = 1024;

	localparam int unsigned RELEASE_W = 16;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned GRANT_W   = 10;
	localparam int unsigned COUNT_W   = 11;

	// s_axis_tdata: release_index, padded to whole bytes
	localparam int unsigned S_TDATA_W = ((RELEASE_W + 7) / 8) * 8;
	// m_axis_tdata: granted_index, in_use, peak_in_use
	localparam int unsigned M_TDATA_W = ((GRANT_W + 2 * COUNT_W + 7) / 8) * 8;

	typedef enum logic {
		FUNC_ALLOC   = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED   = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_RELEASED  = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

endpackage

### hw/rtl/lipa_ram.sv
// ----------------------------------------------------------------------------
// lipa_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module lipa_ram
	import lipa_pkg::*;
#(
	parameter int unsigned DEPTH  = POOL_ENTRIES_DEF,
	parameter int unsigned WIDTH  = 1,
	localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/lifo_index_pool_allocator.sv
// ----------------------------------------------------------------------------
// lifo_index_pool_allocator
// Hands out pool indices from a LIFO free stack; releases push them back.
// ----------------------------------------------------------------------------
// The cycle a request is accepted (IDLE) launches the registered reads of
// the free stack and of the busy map; in EXEC, once the output register is
// empty or being taken, the block does the read-modify-write and loads the
// result register. A new request is accepted while a result still waits to
// be taken. No clearing pass follows reset: a low-water mark of the stack
// depth tells which stack slots still hold their reset index and which
// busy-map entries have never been written, so the block is ready straight
// out of reset.
module lifo_index_pool_allocator
	import lipa_pkg::*;
#(
	parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF,
	localparam int unsigned IDX_W = $clog2(POOL_ENTRIES),
	localparam int unsigned CNT_W = $clog2(POOL_ENTRIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // release_index
	input  logic                 s_axis_tuser,  // func
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,  // granted_index, in_use, peak_in_use
	output logic [STATUS_W-1:0]  m_axis_tuser   // status
);

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	localparam logic [CNT_W-1:0]       POOL_CNT = CNT_W'(POOL_ENTRIES);
	localparam logic [RELEASE_W:0]     POOL_LIM = (RELEASE_W + 1)'(POOL_ENTRIES);

	state_t               state_q;
	logic [CNT_W-1:0]     depth_q;
	logic [CNT_W-1:0]     low_q;
	logic [CNT_W-1:0]     used_q;
	logic [CNT_W-1:0]     peak_q;
	logic                 m_valid_q;
	status_t              status_q;
	logic [GRANT_W-1:0]   grant_q;
	logic [COUNT_W-1:0]   in_use_q;
	logic [COUNT_W-1:0]   peak_out_q;

	func_t                func_s1;
	logic [IDX_W-1:0]     rel_idx_s1;
	logic                 rel_ok_s1;

	logic                 accept;
	logic                 commit;
	logic [RELEASE_W-1:0] rel_in;
	logic [CNT_W-1:0]     slot;
	logic                 fresh;
	logic [IDX_W-1:0]     stack_rd;
	logic                 busy_rd;
	logic                 rel_busy;
	logic [IDX_W-1:0]     alloc_idx;

	status_t              status_d;
	logic [IDX_W-1:0]     grant_d;
	logic [CNT_W-1:0]     depth_d;
	logic [CNT_W-1:0]     low_d;
	logic [CNT_W-1:0]     used_d;
	logic [CNT_W-1:0]     peak_d;
	logic                 stack_we;
	logic                 busy_we;
	logic [IDX_W-1:0]     busy_waddr;
	logic                 busy_wdata;

	assign rel_in        = s_axis_tdata[RELEASE_W-1:0];
	assign s_axis_tready = (state_q == IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign commit        = (state_q == EXEC) && (!m_valid_q || m_axis_tready);

	lipa_ram #(
		.DEPTH (POOL_ENTRIES),
		.WIDTH (IDX_W)
	) u_stack (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (slot[IDX_W-1:0]),
		.rd_data (stack_rd),
		.wr_en   (stack_we),
		.wr_addr (depth_q[IDX_W-1:0]),
		.wr_data (rel_idx_s1)
	);

	lipa_ram #(
		.DEPTH (POOL_ENTRIES),
		.WIDTH (1)
	) u_busy (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rel_in[IDX_W-1:0]),
		.rd_data (busy_rd),
		.wr_en   (busy_we),
		.wr_addr (busy_waddr),
		.wr_data (busy_wdata)
	);

	// slots below the low-water mark were never written: they hold their own index
	assign slot      = depth_q - CNT_W'(1);
	assign fresh     = (slot < low_q);
	assign alloc_idx = fresh ? slot[IDX_W-1:0] : stack_rd;
	// busy entries below the low-water mark were never written: free
	assign rel_busy  = rel_ok_s1 && (CNT_W'(rel_idx_s1) >= low_q) && busy_rd;

	always_comb begin
		status_d   = ST_IGNORED;
		grant_d    = '0;
		depth_d    = depth_q;
		low_d      = low_q;
		used_d     = used_q;
		peak_d     = peak_q;
		stack_we   = 1'b0;
		busy_we    = 1'b0;
		busy_waddr = rel_idx_s1;
		busy_wdata = 1'b0;
		case (func_s1)
			FUNC_ALLOC: begin
				if (depth_q == '0) begin
					status_d = ST_EXHAUSTED;
				end else begin
					status_d   = ST_GRANTED;
					grant_d    = alloc_idx;
					depth_d    = slot;
					low_d      = fresh ? slot : low_q;
					used_d     = used_q + CNT_W'(1);
					peak_d     = (used_d > peak_q) ? used_d : peak_q;
					busy_we    = commit;
					busy_waddr = alloc_idx;
					busy_wdata = 1'b1;
				end
			end
			FUNC_RELEASE: begin
				if (rel_busy && (depth_q != POOL_CNT)) begin
					status_d = ST_RELEASED;
					depth_d  = depth_q + CNT_W'(1);
					used_d   = (used_q != '0) ? used_q - CNT_W'(1) : used_q;
					stack_we = commit;
					busy_we  = commit;
				end
			end
			default: begin
				status_d = ST_IGNORED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			depth_q   <= POOL_CNT;
			low_q     <= POOL_CNT;
			used_q    <= '0;
			peak_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (commit) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (commit) begin
				depth_q   <= depth_d;
				low_q     <= low_d;
				used_q    <= used_d;
				peak_q    <= peak_d;
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= func_t'(s_axis_tuser);
			rel_idx_s1 <= rel_in[IDX_W-1:0];
			rel_ok_s1  <= ({1'b0, rel_in} < POOL_LIM);
		end
		if (commit) begin
			status_q   <= status_d;
			grant_q    <= GRANT_W'(grant_d);
			in_use_q   <= COUNT_W'(used_d);
			peak_out_q <= COUNT_W'(peak_d);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = M_TDATA_W'({peak_out_q, in_use_q, grant_q});

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lifo_index_pool_allocator: a directed table of
// allocate/release requests, then a fill-to-exhaustion and drain sweep with
// random content, checked against the table's expected replies or against a scoreboard model of the free stack.
// ----------------------------------------------------------------------------
module testbench;
	import lipa_pkg::*;

	localparam int unsigned POOL  = POOL_ENTRIES_DEF;
	localparam int unsigned DIR_N = 23;
	localparam int unsigned LONG_STALL = 300;

	typedef struct packed {
		status_t              st;
		logic [GRANT_W-1:0]   gi;
		logic [COUNT_W-1:0]   used;
		logic [COUNT_W-1:0]   peak;
	} pool_reply_t;

	typedef struct packed {
		func_t         fn;
		logic [15:0]   idx;
		logic          typed;
		pool_reply_t   want;
	} req_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]  m_axis_tuser;

	// scoreboard model of the pool
	logic [GRANT_W-1:0] free_idx [POOL];
	bit                 taken [POOL];
	int                 free_cnt;
	int                 used_cnt;
	int                 peak_cnt;
	int                 last_grant;

	pool_reply_t replies_due [$];
	int          mismatches;
	int          idle_phase;
	int          stall_left;
	bit          long_stall_done;
	int          status_seen [4];
	int          sent;

	// first row: after reset the top of the stack is the highest index
	req_row_t dir_tab [DIR_N] = '{
		'{FUNC_ALLOC,   16'd0,     1'b1, '{ST_GRANTED,   10'd1023, 11'd1, 11'd1}},
		'{FUNC_ALLOC,   16'd0,     1'b1, '{ST_GRANTED,   10'd1022, 11'd2, 11'd2}},
		'{FUNC_RELEASE, 16'd1022,  1'b1, '{ST_RELEASED,  10'd0,    11'd1, 11'd2}},
		'{FUNC_RELEASE, 16'd1022,  1'b1, '{ST_IGNORED,   10'd0,    11'd1, 11'd2}},
		'{FUNC_RELEASE, 16'd1024,  1'b1, '{ST_IGNORED,   10'd0,    11'd1, 11'd2}},
		'{FUNC_RELEASE, 16'hFFFF,  1'b1, '{ST_IGNORED,   10'd0,    11'd1, 11'd2}},
		'{FUNC_RELEASE, 16'd0,     1'b1, '{ST_IGNORED,   10'd0,    11'd1, 11'd2}},
		'{FUNC_ALLOC,   16'hFFFF,  1'b1, '{ST_GRANTED,   10'd1022, 11'd2, 11'd2}},
		'{FUNC_RELEASE, 16'd1023,  1'b1, '{ST_RELEASED,  10'd0,    11'd1, 11'd2}},
		'{FUNC_RELEASE, 16'd1022,  1'b1, '{ST_RELEASED,  10'd0,    11'd0, 11'd2}},
		'{FUNC_RELEASE, 16'd5,     1'b1, '{ST_IGNORED,   10'd0,    11'd0, 11'd2}},
		'{FUNC_ALLOC,   16'd0,     1'b1, '{ST_GRANTED,   10'd1022, 11'd1, 11'd2}},
		'{FUNC_ALLOC,   16'd0,     1'b1, '{ST_GRANTED,   10'd1023, 11'd2, 11'd2}},
		'{FUNC_ALLOC,   16'd0,     1'b1, '{ST_GRANTED,   10'd1021, 11'd3, 11'd3}},
		'{FUNC_RELEASE, 16'd1023,  1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}},
		'{FUNC_RELEASE, 16'd1021,  1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}},
		'{FUNC_ALLOC,   16'h5555,  1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}},
		'{FUNC_RELEASE, 16'h5555,  1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}},
		'{FUNC_RELEASE, 16'hAAAA,  1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}},
		'{FUNC_ALLOC,   16'hAAAA,  1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}},
		'{FUNC_ALLOC,   16'd0,     1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}},
		'{FUNC_RELEASE, 16'd1022,  1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}},
		'{FUNC_RELEASE, 16'd1023,  1'b0, '{ST_GRANTED,   10'd0,    11'd0, 11'd0}}
	};

	lifo_index_pool_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40) begin
			$display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	// advance the pool model by one request
	function automatic pool_reply_t pool_step(input func_t fn, input logic [15:0] idx);
		pool_reply_t r;
		r = '0;
		if (fn == FUNC_ALLOC) begin
			if (free_cnt == 0) begin
				r.st = ST_EXHAUSTED;
			end else begin
				free_cnt--;
				r.gi = free_idx[free_cnt];
				taken[r.gi] = 1'b1;
				used_cnt++;
				if (used_cnt > peak_cnt) begin
					peak_cnt = used_cnt;
				end
				last_grant = r.gi;
				r.st = ST_GRANTED;
			end
		end else begin
			if (idx >= POOL || !taken[idx] || free_cnt >= POOL) begin
				r.st = ST_IGNORED;
			end else begin
				taken[idx] = 1'b0;
				free_idx[free_cnt] = idx[GRANT_W-1:0];
				free_cnt++;
				if (used_cnt > 0) begin
					used_cnt--;
				end
				r.st = ST_RELEASED;
			end
		end
		r.used = COUNT_W'(used_cnt);
		r.peak = COUNT_W'(peak_cnt);
		return r;
	endfunction

	// mostly busy entries; the rest double frees, stale grants and bad indices
	function automatic logic [15:0] pick_release();
		int r;
		int s;
		r = $urandom_range(99);
		if (r < 75 && used_cnt > 0) begin
			s = $urandom_range(POOL - 1);
			while (!taken[s]) begin
				s = (s + 1) % POOL;
			end
			return 16'(s);
		end else if (r < 85) begin
			return 16'(last_grant);
		end else if (r < 93) begin
			return 16'($urandom_range(POOL - 1));
		end else if (r < 97) begin
			return 16'($urandom_range(65535, POOL));
		end
		return 16'($urandom);
	endfunction

	task automatic send_request(input func_t fn, input logic [15:0] idx, input logic typed,
			input pool_reply_t typed_want, output pool_reply_t pred);
		int tx_pct;
		tx_pct = (idle_phase == 0) ? 32 : (idle_phase == 1) ? 45 : 0;
		while ($urandom_range(99) < tx_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= fn;
		s_axis_tdata  <= idx;
		do @(posedge clk); while (!s_axis_tready);
		pred = pool_step(fn, idx);
		replies_due.push_back(typed ? typed_want : pred);
		sent++;
	endtask

	// output side: random backpressure plus one long hold-off in the last phase
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_phase == 2 && !long_stall_done) begin
				long_stall_done = 1'b1;
				stall_left = LONG_STALL - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= ((idle_phase == 0) ? 45 :
					(idle_phase == 1) ? 32 : 0));
			end
		end
	end

	always @(posedge clk) begin : reply_check
		pool_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			status_seen[m_axis_tuser]++;
			if (replies_due.size() == 0) begin
				report_mismatch("reply with nothing pending, status", m_axis_tuser, 0);
			end else begin
				want = replies_due.pop_front();
				if (m_axis_tuser != want.st) begin
					report_mismatch("status", m_axis_tuser, want.st);
				end
				if (m_axis_tdata[GRANT_W-1:0] != want.gi) begin
					report_mismatch("granted_index", m_axis_tdata[GRANT_W-1:0], want.gi);
				end
				if (m_axis_tdata[GRANT_W +: COUNT_W] != want.used) begin
					report_mismatch("in_use", m_axis_tdata[GRANT_W +: COUNT_W], want.used);
				end
				if (m_axis_tdata[GRANT_W + COUNT_W +: COUNT_W] != want.peak) begin
					report_mismatch("peak_in_use", m_axis_tdata[GRANT_W + COUNT_W +: COUNT_W],
						want.peak);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d replies outstanding", replies_due.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		pool_reply_t pred;
		func_t       fn;
		int          n_rand;
		int          exhausted;
		int          drained;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_ALLOC;
		mismatches    = 0;
		idle_phase    = 0;
		stall_left    = 0;
		sent          = 0;
		for (int i = 0; i < POOL; i++) begin
			free_idx[i] = GRANT_W'(i);
			taken[i]    = 1'b0;
		end
		free_cnt   = POOL;
		used_cnt   = 0;
		peak_cnt   = 0;
		last_grant = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			send_request(dir_tab[i].fn, dir_tab[i].idx, dir_tab[i].typed, dir_tab[i].want, pred);
		end

		// fill until the pool has run dry eight times, then drain part of it
		n_rand    = 0;
		exhausted = 0;
		drained   = 0;
		while (drained < 50 && n_rand < 2400) begin
			idle_phase = (n_rand < 384) ? 0 : (n_rand < 768) ? 1 : 2;
			if (exhausted < 8) begin
				fn = ($urandom_range(99) < 97) ? FUNC_ALLOC : FUNC_RELEASE;
			end else begin
				fn = ($urandom_range(99) < 20) ? FUNC_ALLOC : FUNC_RELEASE;
				drained++;
			end
			send_request(fn, (fn == FUNC_ALLOC) ? 16'($urandom) : pick_release(), 1'b0,
				'0, pred);
			if (pred.st == ST_EXHAUSTED) begin
				exhausted++;
			end
			n_rand++;
		end
		s_axis_tvalid <= 1'b0;

		while (replies_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("Run: %0d requests (%0d directed), %0d grants, %0d exhausted,",
			sent, DIR_N, status_seen[ST_GRANTED], status_seen[ST_EXHAUSTED]);
		$display("     %0d releases, %0d ignored; peak usage %0d of %0d entries,",
			status_seen[ST_RELEASED], status_seen[ST_IGNORED], peak_cnt, POOL);
		$display("     %0d entries in use at end, one %0d-cycle output stall",
			used_cnt, LONG_STALL);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
